### hw/rtl/ssa_pkg.sv
package ssa_pkg;

  localparam int DIM_W         = 13;
  localparam int POS_W         = 12;
  localparam int IDX_OUT_W     = 4;
  localparam int MAX_PAGES_DEF = 16;
  localparam int CFG_IDX_W     = 1;

  localparam logic [DIM_W-1:0] PAGE_LIMIT = 13'd4096;
  localparam logic [DIM_W-1:0] PAGE_RESET = 13'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_WIDTH  = 1'b0,
    CFG_PAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
  } in_item_t;

  typedef struct packed {
    logic                 granted;
    logic [IDX_OUT_W-1:0] page_index;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic                 opened_page;
  } out_item_t;

  // per-page shelf state as stored in the page memory
  typedef struct packed {
    logic [DIM_W-1:0] cursor_x;
    logic [DIM_W-1:0] row_top;
    logic [DIM_W-1:0] row_height;
  } page_ent_t;

  function automatic logic [DIM_W-1:0] sat_page(input logic [DIM_W-1:0] v);
    return (v > PAGE_LIMIT) ? PAGE_LIMIT : v;
  endfunction

endpackage

### hw/rtl/ssa_chan_if.sv
interface ssa_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/ssa_ram.sv
module ssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/shelf_atlas_space_allocator_core.sv
// Shelf-packing atlas allocator. Each request on in_ch asks for a rectangle and
// gets exactly one result on out_ch: the page and top-left position where it was
// placed, or granted = 0 when it is empty, larger than the page, or when no open
// page fits and all MAX_PAGES pages are in use. Pages are searched first-fit in
// order; the per-page row state lives in a single-port-read memory that is read
// one page per cycle, and a request visits at most MAX_PAGES open pages, while a
// request rejected by size, or one that opens the first page while no page is
// open, skips the scan and goes straight to placement. A new request is taken
// once the previous one has been placed, while its result may still wait on
// out_ch. Page size registers are written through cfg_we/cfg_idx/cfg_wdata; the
// user must write them only while no request is in flight, as the block itself
// does not enforce this. Values above 4096 act as 4096.
module shelf_atlas_space_allocator_core
  import ssa_pkg::*;
#(
  parameter int MAX_PAGES = MAX_PAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ssa_chan_if.sink             in_ch,
  ssa_chan_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  localparam int AW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW  = $clog2(MAX_PAGES + 1);
  localparam int EW  = $bits(page_ent_t);
  localparam logic [CW-1:0] PAGES_MAX = CW'(MAX_PAGES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE
  } state_t;

  state_t            state_r;
  logic [DIM_W-1:0]  page_w_r, page_h_r;
  logic [DIM_W-1:0]  w_r, h_r, pw_r, ph_r;
  logic              fail_r, opened_r;
  logic [AW-1:0]     found_r;
  page_ent_t         ent_r;
  logic [CW-1:0]     issue_ptr_r;
  logic [AW-1:0]     test_ptr_r;
  logic              rd_pend_r;
  logic [CW-1:0]     pages_used_r;
  out_item_t         out_r;
  logic              out_valid_r;

  in_item_t          in_item;
  logic              in_xfer;
  logic [DIM_W-1:0]  in_pw, in_ph;
  logic              in_bad;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  page_ent_t         rd_ent;
  logic [EW-1:0]     rd_data;
  logic [DIM_W:0]    fit_cx_sum;
  logic [DIM_W+1:0]  fit_rt_sum, fit_nr_sum;
  logic              fits;
  logic              last_page;

  logic [DIM_W:0]    pl_cx_sum;
  logic              pl_newrow;
  logic [DIM_W-1:0]  pl_cx, pl_rt, pl_rh;
  page_ent_t         pl_ent;
  logic              pl_go;
  logic              wr_en;

  assign in_item      = in_ch.data;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign in_pw  = sat_page(page_w_r);
  assign in_ph  = sat_page(page_h_r);
  assign in_bad = (in_item.rect_width == '0) || (in_item.rect_height == '0) ||
                  (in_item.rect_width > in_pw) || (in_item.rect_height > in_ph);

  // scan: issue one read per cycle, test the page whose data returns
  assign rd_en   = (state_r == S_SCAN) && (issue_ptr_r < pages_used_r);
  assign rd_addr = issue_ptr_r[AW-1:0];
  assign rd_ent  = page_ent_t'(rd_data);

  assign fit_cx_sum = {1'b0, rd_ent.cursor_x} + {1'b0, w_r};
  assign fit_rt_sum = {2'b00, rd_ent.row_top} + {2'b00, h_r};
  assign fit_nr_sum = {2'b00, rd_ent.row_top} + {2'b00, rd_ent.row_height} + {2'b00, h_r};
  assign fits = ((fit_cx_sum <= {1'b0, pw_r}) && (fit_rt_sum <= {2'b00, ph_r})) ||
                (fit_nr_sum <= {2'b00, ph_r});
  assign last_page = ((CW'(test_ptr_r) + CW'(1)) == pages_used_r);

  // placement on the chosen page
  assign pl_cx_sum = {1'b0, ent_r.cursor_x} + {1'b0, w_r};
  assign pl_newrow = pl_cx_sum > {1'b0, pw_r};
  assign pl_cx     = pl_newrow ? '0 : ent_r.cursor_x;
  assign pl_rt     = pl_newrow ? DIM_W'(ent_r.row_top + ent_r.row_height) : ent_r.row_top;
  assign pl_rh     = pl_newrow ? '0 : ent_r.row_height;

  always_comb begin
    pl_ent.cursor_x   = DIM_W'(pl_cx + w_r);
    pl_ent.row_top    = pl_rt;
    pl_ent.row_height = (h_r > pl_rh) ? h_r : pl_rh;
  end

  assign pl_go = (state_r == S_PLACE) && (!out_valid_r || out_ch.ready);
  assign wr_en = pl_go && !fail_r;

  ssa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_PAGES),
    .AW    (AW)
  ) u_pages (
    .clk   (clk),
    .we    (wr_en),
    .waddr (found_r),
    .wdata (EW'(pl_ent)),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      page_w_r     <= PAGE_RESET;
      page_h_r     <= PAGE_RESET;
      pages_used_r <= '0;
      out_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
      issue_ptr_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_PAGE_WIDTH:  page_w_r <= cfg_wdata;
          CFG_PAGE_HEIGHT: page_h_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (pl_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      rd_pend_r <= rd_en;
      if (rd_en) begin
        issue_ptr_r <= issue_ptr_r + CW'(1);
        test_ptr_r  <= rd_addr;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            w_r         <= in_item.rect_width;
            h_r         <= in_item.rect_height;
            pw_r        <= in_pw;
            ph_r        <= in_ph;
            fail_r      <= in_bad;
            opened_r    <= 1'b0;
            issue_ptr_r <= '0;
            if (in_bad) begin
              state_r <= S_PLACE;
            end else if (pages_used_r == '0) begin
              // nothing open yet: go straight to a fresh page
              found_r      <= '0;
              ent_r        <= '0;
              opened_r     <= 1'b1;
              pages_used_r <= pages_used_r + CW'(1);
              state_r      <= S_PLACE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_pend_r) begin
            if (fits) begin
              found_r <= test_ptr_r;
              ent_r   <= rd_ent;
              state_r <= S_PLACE;
            end else if (last_page) begin
              if (pages_used_r == PAGES_MAX) begin
                fail_r <= 1'b1;
              end else begin
                found_r      <= pages_used_r[AW-1:0];
                ent_r        <= '0;
                opened_r     <= 1'b1;
                pages_used_r <= pages_used_r + CW'(1);
              end
              state_r <= S_PLACE;
            end
          end
        end
        S_PLACE: begin
          if (pl_go) begin
            if (fail_r) begin
              out_r <= '0;
            end else begin
              out_r.granted     <= 1'b1;
              out_r.page_index  <= IDX_OUT_W'(found_r);
              out_r.pos_x       <= pl_cx[POS_W-1:0];
              out_r.pos_y       <= pl_rt[POS_W-1:0];
              out_r.opened_page <= opened_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
